/* rtl/mpd_pkg.sv */
// mpd_pkg: types, codes and reset constants of the motor position pid drive
// depends on: nothing
`default_nettype none

package mpd_pkg;

  // register reset values
  localparam logic [15:0] PROP_GAIN_RST   = 16'd512;
  localparam logic [31:0] INTEG_GAIN_RST  = 32'd42950;
  localparam logic [15:0] INTEG_ZONE_RST  = 16'd100;
  localparam logic [15:0] INNER_ZONE_RST  = 16'd10;
  localparam logic [15:0] ACCEPT_ERR_RST  = 16'd0;
  localparam logic [15:0] ACTIVE_ERR_RST  = 16'd1;
  localparam logic [7:0]  MAX_DRIVE_RST   = 8'd255;
  localparam logic        REVERSED_RST    = 1'b0;

  // integral saturates symmetrically at +-(2^63 - 1)
  localparam logic [63:0] INTEG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] INTEG_MIN = 64'h8000_0000_0000_0001;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_INTEG_ZONE = 3'd2,
    REG_INNER_ZONE = 3'd3,
    REG_ACCEPT_ERR = 3'd4,
    REG_ACTIVE_ERR = 3'd5,
    REG_MAX_DRIVE  = 3'd6,
    REG_REVERSED   = 3'd7
  } reg_idx_t;

  // sequencer states, one per step of a control tick
  typedef enum logic [3:0] {
    S_IDLE,
    S_ABS,
    S_MUL_DT,
    S_INTEG,
    S_ACC_P,
    S_MUL_I0,
    S_ACC_I0,
    S_ACC_I1,
    S_MAG,
    S_FIN
  } state_t;

  // operand pairs of the shared multiplier
  typedef enum logic [1:0] {
    MUL_ERR_DT,
    MUL_ERR_KP,
    MUL_INT_LO,
    MUL_INT_HI
  } mul_sel_t;

  // control from the sequencer to the datapath
  typedef struct packed {
    logic     busy;
    logic     ld_abs;
    logic     ld_integ;
    logic     ld_acc_p;
    logic     ld_acc_i0;
    logic     ld_acc_i1;
    logic     ld_mag;
    logic     ld_out;
    logic     mul_en;
    mul_sel_t mul_sel;
  } ctrl_t;

endpackage

`default_nettype wire

/* rtl/mpd_mul.sv */
// mpd_mul: shared unsigned 33 x 32 multiplier with registered product
// depends on: nothing
`default_nettype none

module mpd_mul (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [32:0] a,
  input  wire logic [31:0] b,
  output logic      [64:0] prod
);

  // product register, loaded when the sequencer uses the unit
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * {1'b0, b};
    end
  end

endmodule

`default_nettype wire

/* rtl/mpd_seq.sv */
// mpd_seq: step sequencer of one control tick
// depends on: mpd_pkg
`default_nettype none

module mpd_seq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          drive_go,
  input  wire logic          out_free,
  output mpd_pkg::ctrl_t     ctrl
);

  mpd_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and step controls
  always_comb begin
    state_next     = state;
    ctrl           = '0;
    ctrl.busy      = 1'b1;
    ctrl.mul_sel   = mpd_pkg::MUL_ERR_DT;
    case (state)
      mpd_pkg::S_IDLE: begin
        ctrl.busy = 1'b0;
        if (in_valid) begin
          state_next = mpd_pkg::S_ABS;
        end
      end
      mpd_pkg::S_ABS: begin
        ctrl.ld_abs = 1'b1;
        state_next  = mpd_pkg::S_MUL_DT;
      end
      mpd_pkg::S_MUL_DT: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = mpd_pkg::MUL_ERR_DT;
        state_next   = mpd_pkg::S_INTEG;
      end
      mpd_pkg::S_INTEG: begin
        ctrl.ld_integ = 1'b1;
        ctrl.mul_en   = 1'b1;
        ctrl.mul_sel  = mpd_pkg::MUL_ERR_KP;
        state_next    = drive_go ? mpd_pkg::S_ACC_P : mpd_pkg::S_FIN;
      end
      mpd_pkg::S_ACC_P: begin
        ctrl.ld_acc_p = 1'b1;
        state_next    = mpd_pkg::S_MUL_I0;
      end
      mpd_pkg::S_MUL_I0: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = mpd_pkg::MUL_INT_LO;
        state_next   = mpd_pkg::S_ACC_I0;
      end
      mpd_pkg::S_ACC_I0: begin
        ctrl.ld_acc_i0 = 1'b1;
        ctrl.mul_en    = 1'b1;
        ctrl.mul_sel   = mpd_pkg::MUL_INT_HI;
        state_next     = mpd_pkg::S_ACC_I1;
      end
      mpd_pkg::S_ACC_I1: begin
        ctrl.ld_acc_i1 = 1'b1;
        state_next     = mpd_pkg::S_MAG;
      end
      mpd_pkg::S_MAG: begin
        ctrl.ld_mag = 1'b1;
        state_next  = mpd_pkg::S_FIN;
      end
      mpd_pkg::S_FIN: begin
        if (out_free) begin
          ctrl.ld_out = 1'b1;
          state_next  = mpd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mpd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/motor_position_pid_drive.sv */
// motor_position_pid_drive: position pi drive with integral zone, one tick per request
// depends on: mpd_pkg, mpd_mul, mpd_seq
//
//   channel   handshake             payload
//   input     in_valid / in_stall   target_position, position, elapsed_us
//   output    out_valid / out_stall drive_level, direction, motor_enabled, is_active
//   config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// with the drive on a request passes the abs, mul_dt, integ, acc_p, mul_i0, acc_i0, acc_i1,
// mag and fin steps, with it off it goes from integ straight to fin; the steps are the passes through
// the single 33 x 32 multiplier and the 98-bit accumulator.
// in_stall stays high from acceptance until the result is loaded into the output register,
// so the next request is taken while the previous result waits on out_stall.
// rst is synchronous and clears the integral, the active flag and the registers to defaults.
`default_nettype none

module motor_position_pid_drive (
  input  wire logic               clk,
  input  wire logic               rst,
  // tick requests
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] target_position,
  input  wire logic signed [31:0] position,
  input  wire logic        [31:0] elapsed_us,
  // drive results
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic             [7:0]  drive_level,
  output logic                    direction,
  output logic                    motor_enabled,
  output logic                    is_active,
  // configuration writes
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [2:0]  cfg_index,
  input  wire logic        [31:0] cfg_data
);

  // configuration registers
  logic [15:0] prop_gain;
  logic [31:0] integ_gain;
  logic [15:0] integ_zone;
  logic [15:0] inner_zone;
  logic [15:0] acceptable_error;
  logic [15:0] activation_error;
  logic [7:0]  max_drive;
  logic        reversed;

  // tick state and working registers
  logic [63:0] integral;
  logic        active;
  logic [32:0] err;
  logic [31:0] dt;
  logic [32:0] abs_err;
  logic        err_neg;
  logic        drive_on;
  logic        dbl;
  logic [62:0] imag;
  logic        ineg;
  logic [97:0] acc;
  logic [96:0] accmag;
  logic        tneg;

  mpd_pkg::ctrl_t ctrl;
  logic        accept;
  logic        out_free;
  logic        drive_go;
  logic        active_pre;
  logic        in_zone;
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] prod;
  logic [64:0] p_ext;
  logic [64:0] p_signed;
  logic [64:0] isum;
  logic [63:0] int_sat;
  logic [97:0] term_p;
  logic [97:0] term_i0;
  logic [97:0] term_i1;
  logic [7:0]  level_raw;
  logic [7:0]  level;

  assign cfg_ready = 1'b1;
  assign in_stall  = ctrl.busy;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // register writes, masked to register width
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain        <= mpd_pkg::PROP_GAIN_RST;
      integ_gain       <= mpd_pkg::INTEG_GAIN_RST;
      integ_zone       <= mpd_pkg::INTEG_ZONE_RST;
      inner_zone       <= mpd_pkg::INNER_ZONE_RST;
      acceptable_error <= mpd_pkg::ACCEPT_ERR_RST;
      activation_error <= mpd_pkg::ACTIVE_ERR_RST;
      max_drive        <= mpd_pkg::MAX_DRIVE_RST;
      reversed         <= mpd_pkg::REVERSED_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (mpd_pkg::reg_idx_t'(cfg_index))
        mpd_pkg::REG_PROP_GAIN:  prop_gain        <= cfg_data[15:0];
        mpd_pkg::REG_INTEG_GAIN: integ_gain       <= cfg_data;
        mpd_pkg::REG_INTEG_ZONE: integ_zone       <= cfg_data[15:0];
        mpd_pkg::REG_INNER_ZONE: inner_zone       <= cfg_data[15:0];
        mpd_pkg::REG_ACCEPT_ERR: acceptable_error <= cfg_data[15:0];
        mpd_pkg::REG_ACTIVE_ERR: activation_error <= cfg_data[15:0];
        mpd_pkg::REG_MAX_DRIVE:  max_drive        <= cfg_data[7:0];
        mpd_pkg::REG_REVERSED:   reversed         <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // sequencer
  mpd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .drive_go (drive_go),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // shared multiplier operand select
  always_comb begin
    case (ctrl.mul_sel)
      mpd_pkg::MUL_ERR_DT: begin
        mul_a = abs_err;
        mul_b = dt;
      end
      mpd_pkg::MUL_ERR_KP: begin
        mul_a = abs_err;
        mul_b = {16'd0, prop_gain};
      end
      mpd_pkg::MUL_INT_LO: begin
        mul_a = {1'b0, imag[31:0]};
        mul_b = integ_gain;
      end
      mpd_pkg::MUL_INT_HI: begin
        mul_a = {2'b00, imag[62:32]};
        mul_b = integ_gain;
      end
      default: begin
        mul_a = abs_err;
        mul_b = dt;
      end
    endcase
  end

  mpd_mul u_mul (
    .clk  (clk),
    .en   (ctrl.mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // integral step: signed error times time, saturating add
  assign in_zone  = abs_err < {17'd0, integ_zone};
  assign p_ext    = {16'd0, prod[48:0]};
  assign p_signed = err_neg ? (65'd0 - p_ext) : p_ext;
  assign isum     = {integral[63], integral} + p_signed;

  always_comb begin
    if (!isum[64] && isum[63]) begin
      int_sat = mpd_pkg::INTEG_MAX;
    end else if (isum[64] && (!isum[63] || isum[62:0] == 63'd0)) begin
      int_sat = mpd_pkg::INTEG_MIN;
    end else begin
      int_sat = isum[63:0];
    end
  end

  // activation and drive decision
  assign active_pre = active || (abs_err > {17'd0, activation_error});
  assign drive_go   = active_pre && (abs_err > {17'd0, acceptable_error});

  // accumulator terms: p in q.8 moved to q.32, i partial products with optional doubling
  assign term_p  = {25'd0, prod[48:0], 24'd0};
  assign term_i0 = dbl ? {33'd0, prod[63:0], 1'b0} : {34'd0, prod[63:0]};
  assign term_i1 = dbl ? {2'b00, prod[62:0], 33'd0} : {3'b000, prod[62:0], 32'd0};

  // datapath registers of a tick
  always_ff @(posedge clk) begin
    if (accept) begin
      err <= {target_position[31], target_position} - {position[31], position};
      dt  <= elapsed_us;
    end
    if (ctrl.ld_abs) begin
      abs_err <= err[32] ? (33'd0 - err) : err;
      err_neg <= err[32];
    end
    if (ctrl.ld_integ) begin
      drive_on <= drive_go;
      dbl      <= abs_err < {17'd0, inner_zone};
    end
    if (ctrl.ld_acc_p) begin
      acc  <= err_neg ? (98'd0 - term_p) : term_p;
      imag <= integral[63] ? (63'd0 - integral[62:0]) : integral[62:0];
      ineg <= integral[63];
    end
    if (ctrl.ld_acc_i0) begin
      acc <= ineg ? (acc - term_i0) : (acc + term_i0);
    end
    if (ctrl.ld_acc_i1) begin
      acc <= ineg ? (acc - term_i1) : (acc + term_i1);
    end
    if (ctrl.ld_mag) begin
      accmag <= acc[97] ? (97'd0 - acc[96:0]) : acc[96:0];
      tneg   <= acc[97];
    end
  end

  // level: integer part of the sum, limited to max_drive
  always_comb begin
    if ((|accmag[96:40]) || (accmag[39:32] > max_drive)) begin
      level_raw = max_drive;
    end else begin
      level_raw = accmag[39:32];
    end
    level = drive_on ? level_raw : 8'd0;
  end

  // integral and active flag
  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= 64'd0;
      active   <= 1'b0;
    end else begin
      if (ctrl.ld_integ) begin
        integral <= (drive_go && in_zone) ? int_sat : 64'd0;
        active   <= active_pre;
      end
      if (ctrl.ld_out && level == 8'd0) begin
        active <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.ld_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_out) begin
      drive_level   <= level;
      motor_enabled <= level != 8'd0;
      direction     <= (level != 8'd0) && !(tneg ^ reversed);
      is_active     <= active && (level != 8'd0);
    end
  end

  // checks
  a_stop_is_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !motor_enabled |-> drive_level == 8'd0 && !direction && !is_active)
    else $error("stopped result carries drive");

  a_level_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && motor_enabled |-> drive_level != 8'd0 && drive_level <= max_drive)
    else $error("drive level out of range");

  a_integ_symmetric: assert property (@(posedge clk) disable iff (rst)
    integral != 64'h8000_0000_0000_0000)
    else $error("integral passed its negative limit");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("request taken while previous tick in flight");

endmodule

`default_nettype wire

/* test/motor_position_pid_drive_test.sv */
// motor_position_pid_drive_test: self-checking bench for the position pi drive
// drives ticks, config writes and output stalls; predicts each drive request in place
// depends on: mpd_pkg, motor_position_pid_drive
`timescale 1ns / 100ps

module motor_position_pid_drive_test;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  // steps of the largest in-zone error and time in each direction of the ramp
  localparam int unsigned RAMP_TICKS = 10;

  typedef struct packed {
    logic signed [31:0] target;
    logic signed [31:0] pos;
    logic        [31:0] dt;
  } tick_t;

  typedef struct packed {
    logic [7:0] level;
    logic       dir;
    logic       en;
    logic       act;
  } drive_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] target_position = '0;
  logic signed [31:0] position = '0;
  logic        [31:0] elapsed_us = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic        [7:0]  drive_level;
  logic               direction;
  logic               motor_enabled;
  logic               is_active;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic        [2:0]  cfg_index = mpd_pkg::REG_PROP_GAIN;
  logic        [31:0] cfg_data = '0;

  // controller copy: registers and state
  logic        [15:0] kp_q     = mpd_pkg::PROP_GAIN_RST;
  logic        [31:0] ki_q     = mpd_pkg::INTEG_GAIN_RST;
  logic        [15:0] izone_q  = mpd_pkg::INTEG_ZONE_RST;
  logic        [15:0] inner_q  = mpd_pkg::INNER_ZONE_RST;
  logic        [15:0] accept_q = mpd_pkg::ACCEPT_ERR_RST;
  logic        [15:0] act_err_q = mpd_pkg::ACTIVE_ERR_RST;
  logic        [7:0]  max_q    = mpd_pkg::MAX_DRIVE_RST;
  logic               rev_q    = mpd_pkg::REVERSED_RST;
  logic signed [63:0] integ_sum = '0;
  logic               active_q = 1'b0;

  tick_t  tick_queue[$];
  drive_t drive_queue[$];
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  logic in_burst = 1'b0;
  logic out_burst = 1'b0;

  motor_position_pid_drive dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .target_position (target_position),
    .position        (position),
    .elapsed_us      (elapsed_us),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .drive_level     (drive_level),
    .direction       (direction),
    .motor_enabled   (motor_enabled),
    .is_active       (is_active),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #4 clk = ~clk;

  // one control tick of the controller copy, updates integral and active flag
  function automatic drive_t pid_tick(logic signed [31:0] tgt, logic signed [31:0] pos,
                                      logic [31:0] dt);
    logic signed [63:0] err;
    logic signed [63:0] step;
    logic        [63:0] abs_err;
    logic        [63:0] integ_mag;
    logic signed [65:0] acc;
    logic       [127:0] p_term;
    logic       [127:0] i_term;
    logic       [127:0] total;
    logic               neg;
    logic        [7:0]  level;
    drive_t             res;
    err = $signed({{32{tgt[31]}}, tgt}) - $signed({{32{pos[31]}}, pos});
    abs_err = err[63] ? -err : err;
    level = 8'd0;
    neg = 1'b0;
    // integral zone: accumulate error times time with symmetric saturation
    if (abs_err < 64'(izone_q)) begin
      step = err * $signed({32'd0, dt});
      acc = $signed({{2{integ_sum[63]}}, integ_sum}) + $signed({{2{step[63]}}, step});
      if (acc > $signed({2'b00, mpd_pkg::INTEG_MAX}))
        integ_sum = mpd_pkg::INTEG_MAX;
      else if (acc < $signed({2'b11, mpd_pkg::INTEG_MIN}))
        integ_sum = mpd_pkg::INTEG_MIN;
      else
        integ_sum = acc[63:0];
    end else begin
      integ_sum = '0;
    end
    if (abs_err > 64'(act_err_q)) active_q = 1'b1;
    // p and i summed in q.32, sign-magnitude
    if (abs_err > 64'(accept_q) && active_q) begin
      p_term = (128'(abs_err) * 128'(kp_q)) << 24;
      integ_mag = integ_sum[63] ? -integ_sum : integ_sum;
      i_term = 128'(integ_mag) * 128'(ki_q);
      if (abs_err < 64'(inner_q)) i_term = i_term << 1;
      if (err[63] == integ_sum[63]) begin
        total = p_term + i_term;
        neg = err[63];
      end else if (p_term < i_term) begin
        total = i_term - p_term;
        neg = integ_sum[63];
      end else begin
        total = p_term - i_term;
        neg = err[63];
      end
      level = (total[127:32] > 96'(max_q)) ? max_q : total[39:32];
    end else begin
      integ_sum = '0;
    end
    // zero drive stops the motor and drops the active flag
    if (level == 8'd0) begin
      active_q = 1'b0;
      res = '0;
    end else begin
      res.level = level;
      res.dir = ~(neg ^ rev_q);
      res.en = 1'b1;
    end
    res.act = active_q;
    return res;
  endfunction

  // random tick, errors mostly around the integral zone
  function automatic tick_t random_tick(int unsigned span);
    tick_t t;
    int unsigned kind;
    int e;
    kind = $urandom_range(0, 99);
    t.pos = $urandom;
    if (kind < 55) e = int'($urandom_range(0, 2 * span)) - int'(span);
    else if (kind < 70) e = int'($urandom_range(0, 140000)) - 70000;
    else if (kind < 80) e = int'($urandom_range(0, 4)) - 2;
    else e = 0;
    t.target = (kind >= 80) ? $urandom : t.pos + e;
    case ($urandom_range(0, 9))
      0, 1: t.dt = $urandom;
      2: t.dt = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
      3, 4: t.dt = $urandom_range(0, 20);
      default: t.dt = $urandom_range(500, 1500);
    endcase
    return t;
  endfunction

  task automatic queue_tick(logic [31:0] tgt, logic [31:0] pos, logic [31:0] dt);
    tick_t t;
    t.target = tgt;
    t.pos = pos;
    t.dt = dt;
    tick_queue.push_back(t);
  endtask

  // tick with a given error and a position away from the wrap point
  task automatic push_err(int e, logic [31:0] dt);
    logic [31:0] pos;
    pos = $urandom_range(0, 32'h3FFF_FFFF);
    queue_tick(pos + e, pos, dt);
  endtask

  // wait until every request is taken and every drive result is back
  task automatic wait_idle();
    do @(posedge clk);
    while (tick_queue.size() != 0 || in_valid || drive_queue.size() != 0);
  endtask

  task automatic write_reg(mpd_pkg::reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      mpd_pkg::REG_PROP_GAIN:  kp_q = val[15:0];
      mpd_pkg::REG_INTEG_GAIN: ki_q = val;
      mpd_pkg::REG_INTEG_ZONE: izone_q = val[15:0];
      mpd_pkg::REG_INNER_ZONE: inner_q = val[15:0];
      mpd_pkg::REG_ACCEPT_ERR: accept_q = val[15:0];
      mpd_pkg::REG_ACTIVE_ERR: act_err_q = val[15:0];
      mpd_pkg::REG_MAX_DRIVE:  max_q = val[7:0];
      mpd_pkg::REG_REVERSED:   rev_q = val[0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] kp, logic [31:0] ki, logic [15:0] zone,
                           logic [15:0] inner, logic [15:0] acc, logic [15:0] act,
                           logic [7:0] mx, logic rev);
    write_reg(mpd_pkg::REG_PROP_GAIN, {16'd0, kp});
    write_reg(mpd_pkg::REG_INTEG_GAIN, ki);
    write_reg(mpd_pkg::REG_INTEG_ZONE, {16'd0, zone});
    write_reg(mpd_pkg::REG_INNER_ZONE, {16'd0, inner});
    write_reg(mpd_pkg::REG_ACCEPT_ERR, {16'd0, acc});
    write_reg(mpd_pkg::REG_ACTIVE_ERR, {16'd0, act});
    write_reg(mpd_pkg::REG_MAX_DRIVE, {24'd0, mx});
    write_reg(mpd_pkg::REG_REVERSED, {31'd0, rev});
  endtask

  // random settings, junk above each register's width
  task automatic random_setup();
    logic [15:0] zone;
    logic [15:0] inner;
    logic [15:0] acc;
    logic [15:0] act;
    logic [31:0] ki;
    zone = 16'($urandom_range(0, 400));
    inner = 16'($urandom_range(0, zone));
    acc = 16'($urandom_range(0, 4));
    act = acc + 16'($urandom_range(0, 30));
    case ($urandom_range(0, 3))
      0: ki = $urandom;
      1: ki = 32'd0;
      default: ki = $urandom_range(0, 32'h0100_0000);
    endcase
    write_reg(mpd_pkg::REG_PROP_GAIN, {16'($urandom), 16'($urandom_range(0, 4096))});
    write_reg(mpd_pkg::REG_INTEG_GAIN, ki);
    write_reg(mpd_pkg::REG_INTEG_ZONE, {16'($urandom), zone});
    write_reg(mpd_pkg::REG_INNER_ZONE, {16'($urandom), inner});
    write_reg(mpd_pkg::REG_ACCEPT_ERR, {16'($urandom), acc});
    write_reg(mpd_pkg::REG_ACTIVE_ERR, {16'($urandom), act});
    write_reg(mpd_pkg::REG_MAX_DRIVE, {24'($urandom), 8'($urandom_range(1, 255))});
    write_reg(mpd_pkg::REG_REVERSED, {31'($urandom), 1'($urandom)});
  endtask

  // tick driver: predicts on acceptance, then presents the next request after its gap
  always @(posedge clk) begin : driver_p
    int unsigned gap;
    tick_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        drive_queue.push_back(pid_tick(target_position, position, elapsed_us));
        gap = in_burst ? 0 : $urandom_range(0, 8);
      end else begin
        gap = gap_left;
      end
      if (!in_valid || !in_stall) begin
        if (gap == 0 && tick_queue.size() > 0) begin
          nxt = tick_queue.pop_front();
          in_valid <= 1'b1;
          target_position <= nxt.target;
          position <= nxt.pos;
          elapsed_us <= nxt.dt;
          gap_left <= 0;
        end else begin
          in_valid <= 1'b0;
          gap_left <= (gap > 0) ? gap - 1 : 0;
        end
      end
    end
  end

  // drive monitor: checks each accepted result, then stalls for a random hold
  always @(posedge clk) begin : monitor_p
    int unsigned hold;
    drive_t got;
    drive_t want;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      hold = hold_left;
      if (out_valid && !out_stall) begin
        got = {drive_level, direction, motor_enabled, is_active};
        if (drive_queue.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected drive result: level %0d dir %0b en %0b act %0b",
                     got.level, got.dir, got.en, got.act);
        end else begin
          want = drive_queue.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("drive mismatch: level %0d/%0d dir %0b/%0b en %0b/%0b act %0b/%0b",
                       want.level, got.level, want.dir, got.dir, want.en, got.en,
                       want.act, got.act);
          end
        end
        hold = out_burst ? 0 : $urandom_range(0, 8);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold - 1;
      end else begin
        out_stall <= 1'b0;
        hold_left <= 0;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus_p
    int span;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: activation, zones, truncation and extreme positions
    push_err(0, 1000);
    push_err(1, 1000);
    push_err(2, 1000);
    push_err(-2, 1000);
    push_err(9, 1000);
    push_err(10, 1000);
    push_err(99, 50000);
    push_err(100, 1000);
    push_err(-100, 1000);
    push_err(128, 1000);
    push_err(-60, 0);
    push_err(50, 32'hFFFF_FFFF);
    push_err(-1, 1000);
    queue_tick(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_tick(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
    push_err(0, 1000);
    wait_idle();

    // upper extremes, reversed direction
    write_all(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 8'd255, 1'b1);
    push_err(1, 1);
    push_err(-1, 32'hFFFF_FFFF);
    push_err(65534, 32'hFFFF_FFFF);
    push_err(-65535, 1);
    push_err(0, 1000);
    for (int i = 0; i < 30; i++) tick_queue.push_back(random_tick(70000));
    wait_idle();

    // lower extremes: only huge errors drive, limited to one step
    write_all(16'd1, 32'd1, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 8'd1, 1'b0);
    for (int i = 0; i < 20; i++) tick_queue.push_back(random_tick(100));
    wait_idle();

    // integral ramp both ways at the largest in-zone step, no idling
    in_burst = 1'b1;
    out_burst = 1'b1;
    write_all(16'd256, 32'd1, 16'hFFFF, 16'd0, 16'd0, 16'd0, 8'd200, 1'b0);
    for (int i = 0; i < RAMP_TICKS; i++) push_err(65534, 32'hFFFF_FFFF);
    push_err(70000, 1000);
    for (int i = 0; i < RAMP_TICKS; i++) push_err(-65534, 32'hFFFF_FFFF);
    wait_idle();

    // random settings and ticks, sender holds off at each phase boundary
    for (int ph = 0; ph < 7; ph++) begin
      random_setup();
      in_burst = (ph == 1) ? 1'b1 : (ph == 0) ? 1'b0 : ($urandom_range(0, 2) == 0);
      out_burst = (ph == 1) ? 1'b1 : (ph == 0) ? 1'b0 : ($urandom_range(0, 2) == 0);
      span = int'(izone_q) + 20;
      for (int i = 0; i < 52; i++) tick_queue.push_back(random_tick(span));
      wait_idle();
    end

    repeat (30) @(posedge clk);
    if (errors == 0 && drive_queue.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
